// ===== hw/rtl/fmvw_pkg.sv =====
// ----------------------------------------------------------------------------
// fmvw_pkg
// Shared types, register map and constants of the FM voice register writer.
// ----------------------------------------------------------------------------
package fmvw_pkg;

  localparam int unsigned NumVoicesDef = 9;

  // Command codes
  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_PLAY = 2'd1,
    OP_STOP = 2'd2,
    OP_RSVD = 2'd3   // reserved, gives no writes
  } op_e;

  // Synth register bases
  localparam logic [7:0] RegOpSetup   = 8'h20;
  localparam logic [7:0] RegOpLevel   = 8'h40;
  localparam logic [7:0] RegOpAttack  = 8'h60;
  localparam logic [7:0] RegOpSustain = 8'h80;
  localparam logic [7:0] RegFnumLow   = 8'hA0;
  localparam logic [7:0] RegKeyOn     = 8'hB0;
  localparam logic [7:0] RegFeedback  = 8'hC0;

  // Register values
  localparam logic [7:0] ValSetup0    = 8'h01;
  localparam logic [7:0] ValSetup1    = 8'h21;
  localparam logic [7:0] ValLevel0    = 8'h00;
  localparam logic [7:0] ValLevel1    = 8'h1F;
  localparam logic [7:0] ValAttack    = 8'hE4;
  localparam logic [7:0] ValSustain   = 8'h04;
  localparam logic [7:0] ValMixMode   = 8'h01;
  localparam logic [7:0] ValKeyOff    = 8'h00;

  // Frequency normalisation and scaling by 1000/758
  localparam logic [15:0] FreqHighLimit = 16'd554;
  localparam logic [15:0] FreqLowLimit  = 16'd262;
  localparam logic [2:0]  BlockStart    = 3'd4;
  localparam logic [15:0] FreqSatLimit  = 16'd775;   // largest f with f*1000 < 1023*758
  localparam logic [20:0] FnumRecip     = 21'd1383346; // ceil(2^20 * 1000 / 758)
  localparam int unsigned FnumShift     = 20;
  localparam logic [9:0]  FnumMax       = 10'h3FF;

  // Normalised command held between acceptance and the write sequencer
  typedef struct packed {
    op_e        opcode;
    logic [3:0] voice;
    logic       sustain;
    logic [2:0] block;
    logic [9:0] f_norm;
    logic       f_sat;
  } cmd_t;

  // One register write
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] value;
    logic       last;
    logic [9:0] fnum;
    logic [2:0] block;
  } wr_t;

  // Operator offsets per voice
  function automatic logic [7:0] op_offset(input logic [3:0] voice, input logic second);
    logic [7:0] base;
    begin
      unique case (voice)
        4'd0:    base = 8'h00;
        4'd1:    base = 8'h01;
        4'd2:    base = 8'h02;
        4'd3:    base = 8'h08;
        4'd4:    base = 8'h09;
        4'd5:    base = 8'h0A;
        4'd6:    base = 8'h10;
        4'd7:    base = 8'h11;
        4'd8:    base = 8'h12;
        default: base = 8'h00;
      endcase
      op_offset = second ? (base + 8'h03) : base;
    end
  endfunction

endpackage

// ===== hw/rtl/fm_voice_register_writer.sv =====
// ----------------------------------------------------------------------------
// fm_voice_register_writer
// Expands voice commands into FM synth register address/data writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one request: opcode, voice,
//   frequency in Hz and sustain flag. Output channel (out_valid_o/out_ready_i)
//   delivers the register writes of each request, the final one marked by
//   last_write_o. Init gives 5 writes (8 with modulation enabled), play 2,
//   stop 1; an unused opcode or a voice at or above NUM_VOICES gives none.
//   The first write of a request passes the command register, then the output
//   register. Throughput: one write per cycle from the single output register
//   while the receiver is ready; a request has 1 to 8 writes, and the next
//   request is taken in the cycle its predecessor's last write is loaded, so
//   writes of consecutive requests follow without a gap. When the receiver
//   stalls, the output register holds its write, the sequencer holds its step
//   and the input register fills, then in_ready_o drops. Reset clears all
//   valid flags and modulation_enable to 0.
//   modulation_enable is sampled live, so write it only when idle.
// ----------------------------------------------------------------------------
module fm_voice_register_writer
  import fmvw_pkg::*;
#(
  parameter int unsigned NUM_VOICES = NumVoicesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        modulation_enable_we_i,
  input  logic        modulation_enable_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  voice_index_i,
  input  logic [15:0] frequency_hz_i,
  input  logic        sustain_flag_i,
  // write channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  reg_address_o,
  output logic [7:0]  reg_value_o,
  output logic        last_write_o,
  output logic [9:0]  fnum_value_o,
  output logic [2:0]  block_number_o
);

  logic       mod_en_q;
  logic       cmd_valid_q, cmd_valid_d;
  cmd_t       cmd_q, cmd_d;
  logic [2:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  wr_t        out_q;

  logic       accept;
  logic       keep;      // accepted request produces writes
  logic       load;      // output register takes a new write
  logic       done;      // last write of the held request is loaded
  wr_t        wr;
  logic [2:0] norm_block;
  logic [9:0] norm_f;
  logic       norm_sat;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_en_q <= 1'b0;
    end else if (modulation_enable_we_i) begin
      mod_en_q <= modulation_enable_i;
    end
  end

  // Normalise the frequency on the way into the command register
  fmvw_freq_norm u_freq_norm (
    .freq_i   (frequency_hz_i),
    .block_o  (norm_block),
    .f_norm_o (norm_f),
    .f_sat_o  (norm_sat)
  );

  fmvw_write_gen u_write_gen (
    .cmd_i    (cmd_q),
    .step_i   (step_q),
    .mod_en_i (mod_en_q),
    .wr_o     (wr)
  );

  assign load       = cmd_valid_q && (!out_valid_q || out_ready_i);
  assign done       = load && wr.last;
  assign in_ready_o = !cmd_valid_q || done;
  assign accept     = in_valid_i && in_ready_o;
  // Drop requests for absent voices and the unused opcode
  assign keep       = (voice_index_i < 4'(NUM_VOICES)) && (opcode_i != OP_RSVD);

  always_comb begin
    cmd_d         = cmd_q;
    cmd_valid_d   = cmd_valid_q;
    step_d        = step_q;
    if (load) begin
      step_d = step_q + 3'd1;
    end
    if (done) begin
      cmd_valid_d = 1'b0;
      step_d      = '0;
    end
    if (accept) begin
      cmd_valid_d    = keep;
      step_d         = '0;
      cmd_d.opcode   = op_e'(opcode_i);
      cmd_d.voice    = voice_index_i;
      cmd_d.sustain  = sustain_flag_i;
      cmd_d.block    = norm_block;
      cmd_d.f_norm   = norm_f;
      cmd_d.f_sat    = norm_sat;
    end
  end

  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (load) begin
      out_q <= wr;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign reg_address_o  = out_q.addr;
  assign reg_value_o    = out_q.value;
  assign last_write_o   = out_q.last;
  assign fnum_value_o   = out_q.fnum;
  assign block_number_o = out_q.block;

endmodule

// ===== hw/rtl/fmvw_freq_norm.sv =====
// ----------------------------------------------------------------------------
// fmvw_freq_norm
// Octave normalisation of a frequency in Hz into a block and a scaled value.
// ----------------------------------------------------------------------------
module fmvw_freq_norm
  import fmvw_pkg::*;
(
  input  logic [15:0] freq_i,
  output logic [2:0]  block_o,
  output logic [9:0]  f_norm_o,
  output logic        f_sat_o
);

  logic        h1, h2, h3;
  logic        d1, d2, d3, d4;
  logic [15:0] f_wide;

  // Halving only happens above the high limit, and then never doubling
  assign h1 = freq_i > FreqHighLimit;
  assign h2 = (freq_i >> 1) > FreqHighLimit;
  assign h3 = (freq_i >> 2) > FreqHighLimit;
  assign d1 = freq_i < FreqLowLimit;
  assign d2 = (freq_i << 1) < FreqLowLimit;
  assign d3 = (freq_i << 2) < FreqLowLimit;
  assign d4 = (freq_i << 3) < FreqLowLimit;

  always_comb begin
    if (h3) begin
      f_wide  = freq_i >> 3;
      block_o = BlockStart + 3'd3;
    end else if (h2) begin
      f_wide  = freq_i >> 2;
      block_o = BlockStart + 3'd2;
    end else if (h1) begin
      f_wide  = freq_i >> 1;
      block_o = BlockStart + 3'd1;
    end else if (d4) begin
      f_wide  = freq_i << 4;
      block_o = BlockStart - 3'd4;
    end else if (d3) begin
      f_wide  = freq_i << 3;
      block_o = BlockStart - 3'd3;
    end else if (d2) begin
      f_wide  = freq_i << 2;
      block_o = BlockStart - 3'd2;
    end else if (d1) begin
      f_wide  = freq_i << 1;
      block_o = BlockStart - 3'd1;
    end else begin
      f_wide  = freq_i;
      block_o = BlockStart;
    end
  end

  assign f_sat_o  = f_wide > FreqSatLimit;
  assign f_norm_o = f_wide[9:0];

endmodule

// ===== hw/rtl/fmvw_write_gen.sv =====
// ----------------------------------------------------------------------------
// fmvw_write_gen
// Register write for one step of a held command, with the fnum scaling.
// ----------------------------------------------------------------------------
module fmvw_write_gen
  import fmvw_pkg::*;
(
  input  cmd_t       cmd_i,
  input  logic [2:0] step_i,
  input  logic       mod_en_i,
  output wr_t        wr_o
);

  logic [30:0] product;
  logic [9:0]  fnum;
  logic [7:0]  osc0;
  logic [7:0]  osc1;
  logic [7:0]  setup0;

  assign product = 31'(cmd_i.f_norm) * 31'(FnumRecip);
  assign fnum    = cmd_i.f_sat ? FnumMax : product[FnumShift +: 10];
  assign osc0    = op_offset(cmd_i.voice, 1'b0);
  assign osc1    = op_offset(cmd_i.voice, 1'b1);
  assign setup0  = ValSetup0 | {2'b00, cmd_i.sustain, 5'b00000};

  always_comb begin
    wr_o = '0;
    unique case (cmd_i.opcode)
      OP_INIT: begin
        case (step_i)
          3'd0: begin
            wr_o.addr  = RegOpSetup + osc0;
            wr_o.value = setup0;
          end
          3'd1: begin
            wr_o.addr  = RegOpLevel + osc0;
            wr_o.value = ValLevel0;
          end
          3'd2: begin
            wr_o.addr  = RegOpAttack + osc0;
            wr_o.value = ValAttack;
          end
          3'd3: begin
            wr_o.addr  = RegOpSustain + osc0;
            wr_o.value = ValSustain;
          end
          3'd4: begin
            if (mod_en_i) begin
              wr_o.addr  = RegOpSetup + osc1;
              wr_o.value = ValSetup1;
            end else begin
              wr_o.addr  = RegFeedback + {4'h0, cmd_i.voice};
              wr_o.value = ValMixMode;
              wr_o.last  = 1'b1;
            end
          end
          3'd5: begin
            wr_o.addr  = RegOpLevel + osc1;
            wr_o.value = ValLevel1;
          end
          3'd6: begin
            wr_o.addr  = RegOpAttack + osc1;
            wr_o.value = ValAttack;
          end
          default: begin
            wr_o.addr  = RegOpSustain + osc1;
            wr_o.value = ValSustain;
            wr_o.last  = 1'b1;
          end
        endcase
      end
      OP_PLAY: begin
        wr_o.fnum  = fnum;
        wr_o.block = cmd_i.block;
        if (step_i == 3'd0) begin
          wr_o.addr  = RegFnumLow + {4'h0, cmd_i.voice};
          wr_o.value = fnum[7:0];
        end else begin
          wr_o.addr  = RegKeyOn + {4'h0, cmd_i.voice};
          wr_o.value = {2'b00, 1'b1, cmd_i.block, fnum[9:8]};
          wr_o.last  = 1'b1;
        end
      end
      default: begin
        wr_o.addr  = RegKeyOn + {4'h0, cmd_i.voice};
        wr_o.value = ValKeyOff;
        wr_o.last  = 1'b1;
      end
    endcase
  end

endmodule

// ===== dv/fm_voice_register_writer_test.sv =====
// ----------------------------------------------------------------------------
// fm_voice_register_writer_test
// Drives voice commands into the FM voice register writer and checks every
// register write it emits against an independent prediction of the write
// sequence. Both channels idle at random. The modulation setting is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module fm_voice_register_writer_test;
  import fmvw_pkg::*;

  localparam int unsigned NumVoices   = NumVoicesDef;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned PhaseItems  = 75;
  localparam int unsigned NumPhases   = 6;

  // One predicted register write
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] value;
    logic       last;
    logic [9:0] fnum;
    logic [2:0] block;
  } reg_write_t;

  // Predicts the write sequence of each request and checks the writes
  class fm_write_scoreboard;
    bit          modulation_on;
    reg_write_t  pending_writes[$];
    int unsigned error_count;

    function void add_write(logic [7:0] addr, logic [7:0] value, logic last,
                            logic [9:0] fnum, logic [2:0] block);
      reg_write_t w;
      w.addr  = addr;
      w.value = value;
      w.last  = last;
      w.fnum  = fnum;
      w.block = block;
      pending_writes.push_back(w);
    endfunction

    function void note_command(logic [1:0] opcode, logic [3:0] voice,
                               logic [15:0] freq, logic sustain);
      logic [7:0]  op_base [0:8];
      logic [7:0]  osc0;
      logic [7:0]  osc1;
      int unsigned f;
      int unsigned blk;
      logic [9:0]  fnum;
      op_base = '{8'h00, 8'h01, 8'h02, 8'h08, 8'h09, 8'h0A, 8'h10, 8'h11, 8'h12};
      if (voice >= NumVoices || voice > 4'd8) return;
      osc0 = op_base[voice];
      osc1 = op_base[voice] + 8'h03;
      case (opcode)
        OP_INIT: begin
          add_write(RegOpSetup + osc0, ValSetup0 | {2'b00, sustain, 5'b00000}, 1'b0, '0, '0);
          add_write(RegOpLevel + osc0, ValLevel0, 1'b0, '0, '0);
          add_write(RegOpAttack + osc0, ValAttack, 1'b0, '0, '0);
          add_write(RegOpSustain + osc0, ValSustain, 1'b0, '0, '0);
          if (modulation_on) begin
            add_write(RegOpSetup + osc1, ValSetup1, 1'b0, '0, '0);
            add_write(RegOpLevel + osc1, ValLevel1, 1'b0, '0, '0);
            add_write(RegOpAttack + osc1, ValAttack, 1'b0, '0, '0);
            add_write(RegOpSustain + osc1, ValSustain, 1'b1, '0, '0);
          end else begin
            add_write(RegFeedback + {4'h0, voice}, ValMixMode, 1'b1, '0, '0);
          end
        end
        OP_PLAY: begin
          f   = freq;
          blk = 4;
          while (f > 554 && blk < 7) begin
            f = f / 2;
            blk++;
          end
          while (f < 262 && blk > 0) begin
            f = f * 2;
            blk--;
          end
          if (f * 1000 < 1023 * 758) fnum = 10'(f * 1000 / 758);
          else fnum = 10'h3FF;
          add_write(RegFnumLow + {4'h0, voice}, fnum[7:0], 1'b0, fnum, 3'(blk));
          add_write(RegKeyOn + {4'h0, voice}, {2'b00, 1'b1, 3'(blk), fnum[9:8]}, 1'b1,
                    fnum, 3'(blk));
        end
        OP_STOP: begin
          add_write(RegKeyOn + {4'h0, voice}, ValKeyOff, 1'b1, '0, '0);
        end
        default: ;
      endcase
    endfunction

    function void check_write(logic [7:0] addr, logic [7:0] value, logic last,
                              logic [9:0] fnum, logic [2:0] block);
      reg_write_t want;
      if (pending_writes.size() == 0) begin
        $error("write with nothing expected: reg_address %02h reg_value %02h", addr, value);
        error_count++;
        return;
      end
      want = pending_writes.pop_front();
      if (addr !== want.addr) begin
        $error("reg_address: expected %02h, actual %02h", want.addr, addr);
        error_count++;
      end
      if (value !== want.value) begin
        $error("reg_value: expected %02h, actual %02h", want.value, value);
        error_count++;
      end
      if (last !== want.last) begin
        $error("last_write: expected %0b, actual %0b", want.last, last);
        error_count++;
      end
      if (fnum !== want.fnum) begin
        $error("fnum_value: expected %0d, actual %0d", want.fnum, fnum);
        error_count++;
      end
      if (block !== want.block) begin
        $error("block_number: expected %0d, actual %0d", want.block, block);
        error_count++;
      end
    endfunction
  endclass

  logic        clk_i                  = 1'b0;
  logic        rst_ni                 = 1'b0;
  logic        modulation_enable_we_i = 1'b0;
  logic        modulation_enable_i    = 1'b0;
  logic        in_valid_i             = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i               = '0;
  logic [3:0]  voice_index_i          = '0;
  logic [15:0] frequency_hz_i         = '0;
  logic        sustain_flag_i         = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i            = 1'b1;
  logic [7:0]  reg_address_o;
  logic [7:0]  reg_value_o;
  logic        last_write_o;
  logic [9:0]  fnum_value_o;
  logic [2:0]  block_number_o;

  fm_write_scoreboard scoreboard = new();

  bit          idle_on       = 1'b1;  // random idling on both channels
  bit          long_hold_req = 1'b0;  // ask the receiver for one long stall
  int unsigned cycle_count   = 0;

  fm_voice_register_writer #(
    .NUM_VOICES(NumVoices)
  ) u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .modulation_enable_we_i(modulation_enable_we_i),
    .modulation_enable_i   (modulation_enable_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .opcode_i              (opcode_i),
    .voice_index_i         (voice_index_i),
    .frequency_hz_i        (frequency_hz_i),
    .sustain_flag_i        (sustain_flag_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .reg_address_o         (reg_address_o),
    .reg_value_o           (reg_value_o),
    .last_write_o          (last_write_o),
    .fnum_value_o          (fnum_value_o),
    .block_number_o        (block_number_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Present one request and hold it until it is taken. Valid is left high on
  // return, so a request that follows straight away keeps it up; lower it only
  // when a gap is inserted.
  task automatic send_command(input logic [1:0] op, input logic [3:0] voice,
                              input logic [15:0] freq, input logic sustain);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    opcode_i       <= op;
    voice_index_i  <= voice;
    frequency_hz_i <= freq;
    sustain_flag_i <= sustain;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    scoreboard.note_command(op, voice, freq, sustain);
  endtask

  // Drop valid and wait until every predicted write has come out, then give a
  // request that causes no writes time to leave the block.
  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (scoreboard.pending_writes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the modulation register with the block idle
  task automatic write_modulation(input logic value);
    wait_until_idle();
    modulation_enable_we_i <= 1'b1;
    modulation_enable_i    <= value;
    @(posedge clk_i);
    modulation_enable_we_i <= 1'b0;
    scoreboard.modulation_on = value;
  endtask

  // Receiver: short random stalls, and one long stall on request that backs
  // the block up until it refuses new requests.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_ready_i <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        stall_left = LongHold;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(1, 11);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Check every write taken at a clock edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      scoreboard.check_write(reg_address_o, reg_value_o, last_write_o, fnum_value_o,
                             block_number_o);
    end
  end

  // Cycle watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("fm_voice_register_writer_test: done, errors");
    $finish;
  end

  initial begin
    logic [1:0]  op;
    logic [3:0]  voice;
    logic [15:0] freq;
    logic [15:0] corner_freqs [0:10];
    int unsigned sent;

    corner_freqs = '{16'd0, 16'd1, 16'd261, 16'd262, 16'd554, 16'd555, 16'd4432,
                     16'd4433, 16'd6200, 16'd6208, 16'hFFFF};

    // Hold reset, then release it at a rising edge
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, mixing mode straight from reset
    send_command(OP_INIT, 4'd0, 16'd0, 1'b0);
    send_command(OP_INIT, 4'd8, 16'hFFFF, 1'b1);
    send_command(OP_PLAY, 4'd0, 16'd0, 1'b0);      // zero frequency: block and number 0
    send_command(OP_PLAY, 4'd8, 16'hFFFF, 1'b1);   // saturates at the top block
    send_command(OP_PLAY, 4'd1, 16'd554, 1'b0);
    send_command(OP_PLAY, 4'd2, 16'd555, 1'b0);
    send_command(OP_PLAY, 4'd3, 16'd262, 1'b0);
    send_command(OP_PLAY, 4'd4, 16'd261, 1'b0);
    send_command(OP_PLAY, 4'd5, 16'd1, 1'b0);      // doubles all the way to block 0
    send_command(OP_PLAY, 4'd6, 16'd6200, 1'b0);   // just under saturation
    send_command(OP_PLAY, 4'd7, 16'd6208, 1'b0);   // just over saturation
    send_command(OP_STOP, 4'd3, 16'd0, 1'b0);
    send_command(OP_RSVD, 4'd2, 16'd440, 1'b1);    // unused opcode: no writes
    send_command(OP_INIT, 4'd9, 16'd0, 1'b1);      // voice out of range
    send_command(OP_PLAY, 4'd15, 16'd440, 1'b0);
    send_command(OP_STOP, 4'd12, 16'd0, 1'b0);

    // Directed part with the second operator set up for FM
    write_modulation(1'b1);
    send_command(OP_INIT, 4'd4, 16'd0, 1'b1);
    send_command(OP_INIT, 4'd8, 16'd0, 1'b0);
    send_command(OP_INIT, 4'd15, 16'd0, 1'b1);
    send_command(OP_PLAY, 4'd0, 16'd440, 1'b0);
    send_command(OP_STOP, 4'd8, 16'd0, 1'b0);

    // Random phases, alternating the modulation setting; the last phase runs
    // without idling on either side
    for (int p = 0; p < NumPhases; p++) begin
      write_modulation(p[0]);
      if (p == 2) long_hold_req = 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
        if (sent % 40 == 0) idle_on = (p != NumPhases - 1) && ($urandom_range(0, 3) != 0);
        op    = ($urandom_range(0, 15) == 0) ? OP_RSVD : 2'($urandom_range(0, 2));
        voice = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
        case ($urandom_range(0, 3))
          0:       freq = 16'($urandom());
          1:       freq = 16'($urandom_range(0, 1100));
          2:       freq = corner_freqs[$urandom_range(0, 10)];
          default: freq = 16'($urandom_range(1100, 9000));
        endcase
        send_command(op, voice, freq, 1'($urandom()));
        sent++;
      end
    end

    // Drain and settle, then report
    wait_until_idle();
    if (scoreboard.error_count == 0) begin
      $display("fm_voice_register_writer_test: done, clean");
    end else begin
      $display("fm_voice_register_writer_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fmvw_pkg.sv
hw/rtl/fmvw_freq_norm.sv
hw/rtl/fmvw_write_gen.sv
hw/rtl/fm_voice_register_writer.sv
dv/fm_voice_register_writer_test.sv
